[rtl/cqs_pkg.sv]
// cqs_pkg: shared constants, codes, types and helpers for the circular queue with search
// no dependencies; compiled first
`default_nettype none

package cqs_pkg;

    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int WORD_BITS = 32;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_SRCH = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic  we;
        idx_t  addr;
        word_t data;
    } ring_wr_t;

    // out-of-range capacity acts as the full depth
    function automatic cnt_t eff_cap(input cnt_t cap);
        cnt_t r;
        if (cap == '0 || cap > CNT_W'(DEPTH))
        begin
            r = CNT_W'(DEPTH);
        end
        else
        begin
            r = cap;
        end
        return r;
    endfunction

    function automatic idx_t next_slot(input idx_t i, input cnt_t cap);
        cnt_t n;
        idx_t r;
        n = {1'b0, i} + CNT_W'(1);
        if (n >= cap)
        begin
            r = '0;
        end
        else
        begin
            r = n[IDX_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/cqs_if.sv]
// cqs_req_if and cqs_res_if: valid/ready channels for request and result words
// depends on cqs_pkg
`default_nettype none

interface cqs_req_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            op;
    logic signed [cqs_pkg::WORD_BITS-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface cqs_res_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic                  found;
    logic [cqs_pkg::IDX_W-1:0] slot;
    logic signed [cqs_pkg::WORD_BITS-1:0] head_value;
    logic signed [cqs_pkg::WORD_BITS-1:0] tail_value;
    logic [cqs_pkg::CNT_W-1:0] count;
    logic                  empty_res;
    logic                  full_res;

    modport source (output valid, output status, output found, output slot,
                    output head_value, output tail_value, output count,
                    output empty_res, output full_res, input ready);
    modport sink   (input valid, input status, input found, input slot,
                    input head_value, input tail_value, input count,
                    input empty_res, input full_res, output ready);
endinterface

`default_nettype wire

[rtl/cqs_ring.sv]
// cqs_ring: ring storage, one write port and one read port with registered read data
// depends on cqs_pkg
`default_nettype none

module cqs_ring (
    input  wire logic              clk,
    input  wire cqs_pkg::ring_wr_t wr,
    input  wire cqs_pkg::idx_t     raddr,
    output cqs_pkg::word_t         rdata
);

    cqs_pkg::word_t mem [cqs_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/circular_queue_with_search_core.sv]
// circular_queue_with_search_core: sequencer around the ring with a single compare for search
// an accepted request passes exec, head read, tail read and tail capture before its result;
// a search adds one ring read and one compare per entry scanned, between exec and head read
// throughput: one request at a time, next accepted the cycle after the result word is taken
// reset: rst_n asynchronous active low; empty queue, capacity 64, ring contents undefined
// depends on cqs_pkg, cqs_if, cqs_ring
`default_nettype none

module circular_queue_with_search_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [cqs_pkg::CNT_W-1:0] cfg_wdata,
    cqs_req_if.sink                     req,
    cqs_res_if.source                   res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CMP = 3'd3;
    localparam logic [2:0] S_HEAD_RD  = 3'd4;
    localparam logic [2:0] S_TAIL_RD  = 3'd5;
    localparam logic [2:0] S_TAIL_CAP = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0]      state_reg, state_next;
    cqs_pkg::cnt_t   cap_reg, cap_next;
    cqs_pkg::idx_t   head_reg, head_next;
    cqs_pkg::idx_t   tail_reg, tail_next;
    cqs_pkg::cnt_t   held_reg, held_next;
    cqs_pkg::idx_t   scan_reg, scan_next;
    cqs_pkg::cnt_t   step_reg, step_next;
    logic [1:0]      op_reg, op_next;
    cqs_pkg::word_t  key_reg, key_next;
    logic [1:0]      status_reg, status_next;
    logic            found_reg, found_next;
    cqs_pkg::idx_t   slot_reg, slot_next;
    cqs_pkg::word_t  hval_reg, hval_next;
    cqs_pkg::word_t  tval_reg, tval_next;

    cqs_pkg::cnt_t     cap_eff;
    cqs_pkg::ring_wr_t ring_wr;
    cqs_pkg::idx_t     ring_raddr;
    cqs_pkg::word_t    ring_rdata;

    cqs_ring u_ring (
        .clk   (clk),
        .wr    (ring_wr),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    assign cap_eff = cqs_pkg::eff_cap(cap_reg);

    always_comb
    begin
        state_next  = state_reg;
        cap_next    = cap_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        held_next   = held_reg;
        scan_next   = scan_reg;
        step_next   = step_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        status_next = status_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        hval_next   = hval_reg;
        tval_next   = tval_reg;
        ring_wr     = '0;
        ring_raddr  = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    key_next    = req.value;
                    status_next = cqs_pkg::ST_DONE;
                    found_next  = 1'b0;
                    slot_next   = '0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_HEAD_RD;
                unique case (op_reg)
                    cqs_pkg::OP_ENQ:
                    begin
                        if (held_reg >= cap_eff)
                        begin
                            status_next = cqs_pkg::ST_FULL;
                        end
                        else
                        begin
                            tail_next    = cqs_pkg::next_slot(tail_reg, cap_eff);
                            ring_wr.we   = 1'b1;
                            ring_wr.addr = tail_next;
                            ring_wr.data = key_reg;
                            held_next    = held_reg + cqs_pkg::CNT_W'(1);
                        end
                    end
                    cqs_pkg::OP_DEQ:
                    begin
                        if (held_reg == '0)
                        begin
                            status_next = cqs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            head_next = cqs_pkg::next_slot(head_reg, cap_eff);
                            held_next = held_reg - cqs_pkg::CNT_W'(1);
                        end
                    end
                    cqs_pkg::OP_SRCH:
                    begin
                        if (held_reg == '0)
                        begin
                            status_next = cqs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            scan_next  = head_reg;
                            step_next  = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        status_next = cqs_pkg::ST_DONE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                ring_raddr = scan_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (ring_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = scan_reg;
                    state_next = S_HEAD_RD;
                end
                else if (step_reg + cqs_pkg::CNT_W'(1) == held_reg)
                begin
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    scan_next  = cqs_pkg::next_slot(scan_reg, cap_eff);
                    step_next  = step_reg + cqs_pkg::CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_HEAD_RD:
            begin
                ring_raddr = head_reg;
                state_next = S_TAIL_RD;
            end
            S_TAIL_RD:
            begin
                ring_raddr = tail_reg;
                hval_next  = (held_reg == '0) ? '0 : ring_rdata;
                state_next = S_TAIL_CAP;
            end
            S_TAIL_CAP:
            begin
                tval_next  = (held_reg == '0) ? '0 : ring_rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a capacity write empties the queue
        if (cfg_we)
        begin
            cap_next  = cfg_wdata;
            head_next = '0;
            tail_next = cqs_pkg::IDX_W'(cqs_pkg::eff_cap(cfg_wdata) - cqs_pkg::CNT_W'(1));
            held_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg   <= cqs_pkg::CNT_W'(cqs_pkg::DEPTH);
            head_reg  <= '0;
            tail_reg  <= cqs_pkg::IDX_W'(cqs_pkg::DEPTH - 1);
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        step_reg   <= step_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        hval_reg   <= hval_next;
        tval_reg   <= tval_next;
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign res.valid      = (state_reg == S_OUT);
    assign res.status     = status_reg;
    assign res.found      = found_reg;
    assign res.slot       = slot_reg;
    assign res.head_value = hval_reg;
    assign res.tail_value = tval_reg;
    assign res.count      = held_reg;
    assign res.empty_res  = (held_reg == '0);
    assign res.full_res   = (held_reg == cap_eff);

    a_held_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= cap_eff)
        else $error("held count exceeds capacity");

    a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg == '0 |-> cqs_pkg::next_slot(tail_reg, cap_eff) == head_reg)
        else $error("empty queue with tail not just behind head");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_EXEC)
        else $error("accepted request did not start execution");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.found |-> res.status == cqs_pkg::ST_DONE && !res.empty_res)
        else $error("match reported on a refused request");

endmodule

`default_nettype wire

[bench/tb_circular_queue_with_search_core.sv]
// tb_circular_queue_with_search_core: self-checking bench for the circular queue with search,
// directed and random request words against an in-bench queue predictor, with back-pressure
// depends on cqs_pkg, cqs_if and the circular_queue_with_search_core rtl
`timescale 1ns / 1ps

module tb_circular_queue_with_search_core;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_SHOWN = 40;

    typedef struct packed {
        logic [1:0]     status;
        logic           found;
        cqs_pkg::idx_t  slot;
        cqs_pkg::word_t head_value;
        cqs_pkg::word_t tail_value;
        cqs_pkg::cnt_t  count;
        logic           empty_res;
        logic           full_res;
    } response_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cqs_pkg::cnt_t cfg_wdata;

    cqs_req_if req_ch ();
    cqs_res_if res_ch ();

    circular_queue_with_search_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    // predictor state
    cqs_pkg::word_t shadow_ring [cqs_pkg::DEPTH];
    int             head_pos;
    int             tail_pos;
    int             held_words;
    cqs_pkg::cnt_t  cap_setting;
    response_t      pending_responses [$];

    int fault_count;
    bit calm;
    bit sink_hold;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #(10_000_000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int slot_limit();
        int lim;
        if (cap_setting == '0 || cap_setting > cqs_pkg::cnt_t'(cqs_pkg::DEPTH))
        begin
            lim = cqs_pkg::DEPTH;
        end
        else
        begin
            lim = int'(cap_setting);
        end
        return lim;
    endfunction

    function automatic int advance(input int pos);
        int n;
        n = pos + 1;
        return (n >= slot_limit()) ? 0 : n;
    endfunction

    function automatic response_t compute_response(input logic [1:0] op,
                                                   input cqs_pkg::word_t value);
        response_t r;
        int        pos;
        int        k;
        r = '0;
        r.status = cqs_pkg::ST_DONE;
        case (op)
            cqs_pkg::OP_ENQ:
            begin
                if (held_words >= slot_limit())
                begin
                    r.status = cqs_pkg::ST_FULL;
                end
                else
                begin
                    tail_pos = advance(tail_pos);
                    shadow_ring[tail_pos] = value;
                    held_words++;
                end
            end
            cqs_pkg::OP_DEQ:
            begin
                if (held_words == 0)
                begin
                    r.status = cqs_pkg::ST_EMPTY;
                end
                else
                begin
                    head_pos = advance(head_pos);
                    held_words--;
                end
            end
            cqs_pkg::OP_SRCH:
            begin
                if (held_words == 0)
                begin
                    r.status = cqs_pkg::ST_EMPTY;
                end
                else
                begin
                    pos = head_pos;
                    for (k = 0; k < held_words && !r.found; k++)
                    begin
                        if (shadow_ring[pos] == value)
                        begin
                            r.found = 1'b1;
                            r.slot = cqs_pkg::idx_t'(pos);
                        end
                        else
                        begin
                            pos = advance(pos);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.head_value = (held_words != 0) ? shadow_ring[head_pos] : '0;
        r.tail_value = (held_words != 0) ? shadow_ring[tail_pos] : '0;
        r.count = cqs_pkg::cnt_t'(held_words);
        r.empty_res = (held_words == 0);
        r.full_res = (held_words == slot_limit());
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        fault_count++;
        if (fault_count <= MAX_SHOWN)
        begin
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        end
    endtask

    task automatic check_response();
        response_t want;
        if (pending_responses.size() == 0)
        begin
            flag_mismatch("result word with nothing pending", 1, 0);
        end
        else
        begin
            want = pending_responses.pop_front();
            if (res_ch.status !== want.status)
                flag_mismatch("status", res_ch.status, want.status);
            if (res_ch.found !== want.found)
                flag_mismatch("found", res_ch.found, want.found);
            if (res_ch.slot !== want.slot)
                flag_mismatch("slot", res_ch.slot, want.slot);
            if (res_ch.head_value !== want.head_value)
                flag_mismatch("head_value", res_ch.head_value, want.head_value);
            if (res_ch.tail_value !== want.tail_value)
                flag_mismatch("tail_value", res_ch.tail_value, want.tail_value);
            if (res_ch.count !== want.count)
                flag_mismatch("count", res_ch.count, want.count);
            if (res_ch.empty_res !== want.empty_res)
                flag_mismatch("empty_res", res_ch.empty_res, want.empty_res);
            if (res_ch.full_res !== want.full_res)
                flag_mismatch("full_res", res_ch.full_res, want.full_res);
        end
    endtask

    // result side: check on handshake, then decide ready for the next cycle
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (res_ch.valid && res_ch.ready)
                begin
                    check_response();
                end
                res_ch.ready <= !(sink_hold || (!calm && $urandom_range(0, 99) < 37));
            end
        end
    end

    task automatic send_request(input logic [1:0] op, input cqs_pkg::word_t value);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        pending_responses.push_back(compute_response(op, value));
    endtask

    task automatic set_capacity(input cqs_pkg::cnt_t cap_value);
        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we <= 1'b1;
        cfg_wdata <= cap_value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cap_setting = cap_value;
        head_pos = 0;
        tail_pos = slot_limit() - 1;
        held_words = 0;
    endtask

    function automatic cqs_pkg::word_t random_word();
        int             roll;
        cqs_pkg::word_t w;
        roll = $urandom_range(0, 9);
        if (roll < 3)
        begin
            w = cqs_pkg::word_t'($urandom_range(0, 7)) - cqs_pkg::word_t'(4);
        end
        else if (roll == 3)
        begin
            case ($urandom_range(0, 3))
                0: w = 32'sh8000_0000;
                1: w = 32'sh7fff_ffff;
                2: w = '0;
                default: w = -32'sd1;
            endcase
        end
        else
        begin
            w = cqs_pkg::word_t'($urandom);
        end
        return w;
    endfunction

    // mostly a word that is held, so that matches are common
    function automatic cqs_pkg::word_t search_key();
        int             pos;
        int             k;
        cqs_pkg::word_t w;
        if (held_words != 0 && $urandom_range(0, 99) < 60)
        begin
            pos = head_pos;
            for (k = $urandom_range(0, held_words - 1); k > 0; k--)
            begin
                pos = advance(pos);
            end
            w = shadow_ring[pos];
        end
        else
        begin
            w = random_word();
        end
        return w;
    endfunction

    task automatic test_empty_queue();
        send_request(cqs_pkg::OP_SRCH, '0);
        send_request(cqs_pkg::OP_DEQ, 32'sh7fff_ffff);
        send_request(OP_UNKNOWN, -32'sd1);
    endtask

    task automatic test_extreme_words();
        send_request(cqs_pkg::OP_ENQ, 32'sh8000_0000);
        send_request(cqs_pkg::OP_ENQ, 32'sh7fff_ffff);
        send_request(cqs_pkg::OP_ENQ, '0);
        send_request(cqs_pkg::OP_ENQ, -32'sd1);
        send_request(cqs_pkg::OP_ENQ, 32'sh8000_0000);
        send_request(cqs_pkg::OP_SRCH, 32'sh8000_0000);
        send_request(cqs_pkg::OP_SRCH, -32'sd1);
        send_request(cqs_pkg::OP_SRCH, 32'sd12345);
        send_request(cqs_pkg::OP_DEQ, '0);
        send_request(cqs_pkg::OP_SRCH, 32'sh8000_0000);
        send_request(OP_UNKNOWN, 32'sh5555_5555);
    endtask

    task automatic test_wrap_small_ring();
        set_capacity(cqs_pkg::cnt_t'(3));
        send_request(cqs_pkg::OP_ENQ, 32'sh5555_5555);
        send_request(cqs_pkg::OP_ENQ, 32'shaaaa_aaaa);
        send_request(cqs_pkg::OP_ENQ, 32'sd7);
        send_request(cqs_pkg::OP_ENQ, 32'sd8);
        send_request(cqs_pkg::OP_DEQ, '0);
        send_request(cqs_pkg::OP_ENQ, 32'sd9);
        send_request(cqs_pkg::OP_SRCH, 32'sd9);
        send_request(cqs_pkg::OP_DEQ, '0);
        send_request(cqs_pkg::OP_DEQ, '0);
        send_request(cqs_pkg::OP_DEQ, '0);
        send_request(cqs_pkg::OP_DEQ, '0);
    endtask

    task automatic test_result_backpressure();
        int n;
        set_capacity(cqs_pkg::cnt_t'(8));
        sink_hold <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold <= 1'b0;
            end
        join_none
        for (n = 0; n < 10; n++)
        begin
            send_request((n % 3 == 2) ? cqs_pkg::OP_SRCH : cqs_pkg::OP_ENQ, random_word());
        end
    endtask

    task automatic test_random_phase(input cqs_pkg::cnt_t cap_value, input int items,
                                     input bit quiet);
        int             n;
        int             roll;
        bit             filling;
        logic [1:0]     op;
        cqs_pkg::word_t value;
        set_capacity(cap_value);
        calm = quiet;
        filling = 1'b1;
        for (n = 0; n < items; n++)
        begin
            if (held_words == 0)
                filling = 1'b1;
            else if (held_words >= slot_limit())
                filling = 1'b0;
            else if ($urandom_range(0, 99) < 3)
                filling = !filling;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_UNKNOWN;
            else if (roll < 28)
                op = cqs_pkg::OP_SRCH;
            else if ($urandom_range(0, 99) < 75)
                op = filling ? cqs_pkg::OP_ENQ : cqs_pkg::OP_DEQ;
            else
                op = filling ? cqs_pkg::OP_DEQ : cqs_pkg::OP_ENQ;
            value = (op == cqs_pkg::OP_SRCH) ? search_key() : random_word();
            send_request(op, value);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.op <= cqs_pkg::OP_ENQ;
        req_ch.value <= '0;
        fault_count = 0;
        calm = 1'b0;
        sink_hold <= 1'b0;
        cap_setting = cqs_pkg::cnt_t'(cqs_pkg::DEPTH);
        head_pos = 0;
        tail_pos = cqs_pkg::DEPTH - 1;
        held_words = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_extreme_words();
        test_wrap_small_ring();
        test_result_backpressure();
        test_random_phase(cqs_pkg::cnt_t'(1), 80, 1'b0);
        test_random_phase(cqs_pkg::cnt_t'(2), 80, 1'b0);
        test_random_phase(cqs_pkg::cnt_t'(5), 110, 1'b0);
        test_random_phase(cqs_pkg::cnt_t'(0), 170, 1'b0);
        test_random_phase(cqs_pkg::cnt_t'(127), 100, 1'b0);
        test_random_phase(cqs_pkg::cnt_t'(65), 100, 1'b0);
        test_random_phase(cqs_pkg::cnt_t'(17), 110, 1'b1);
        test_random_phase(cqs_pkg::cnt_t'(64), 190, 1'b0);

        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
